// ===== src/slsrc_pkg.sv =====
// Shared types and codes for the single-line sector read cache.
// No dependencies; every other file in src imports this package.
package slsrc_pkg;

    localparam int unsigned SECTOR_BYTES = 512;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_FILL = 2'd1,
        OP_FAIL = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FAIL  = 2'd1,
        KIND_FWD   = 2'd2,
        KIND_FETCH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sector;
        logic [8:0]  byte_offset;
        logic [9:0]  byte_count;
        logic [7:0]  fill_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] fetch_sector;
        logic [8:0]  fetch_offset;
        logic [9:0]  fetch_count;
        logic        last_byte;
        logic [31:0] hits_seen;
        logic [31:0] misses_seen;
    } rsp_t;

endpackage

// ===== src/single_line_sector_read_cache.sv =====
// Single-line sector read cache: top level with line memory and control sequencer.
// Depends on slsrc_pkg (request/result structs, opcode, kind and state codes).
//
//   channel   signals                      handshake
//   --------  ---------------------------  ------------------------------------
//   request   request (req_t)              beat taken when start & !busy
//   result    result (rsp_t)               beat shown one cycle, result_valid
//
// A read request goes through the chunk split in ST_DIV (reciprocal multiply), then
// in ST_DECIDE (correction and tag compare), which registers a forward or line fetch
// beat; on a hit the block instead streams one byte per cycle from the line memory.
// Fill bytes and fill failures are each taken as a single beat in ST_IDLE; the last
// fill byte starts the byte stream. Reset clears the tag, valid, counters and state;
// the line memory holds garbage until filled. The receiver cannot stall results.
module single_line_sector_read_cache #(
    parameter int unsigned LINE_BYTES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  slsrc_pkg::req_t    request,
    output slsrc_pkg::rsp_t    result,
    output logic               result_valid
);
    import slsrc_pkg::*;

    localparam int unsigned AW    = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int unsigned CW    = $clog2(LINE_BYTES + 1);
    localparam int unsigned CKW   = $clog2((511 / LINE_BYTES) + 1);
    localparam int unsigned SH    = 11;
    localparam logic [11:0] RECIP = 12'((1 << SH) / LINE_BYTES);
    localparam logic [16:0] LB17  = 17'(LINE_BYTES);
    localparam logic [10:0] LB11  = 11'(LINE_BYTES);
    localparam logic [AW-1:0] LAST_POS = AW'(LINE_BYTES - 1);

    // line memory
    logic [7:0]    line_mem [LINE_BYTES];
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    rd_data_reg;

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [8:0]    q0_reg, q0_next;
    logic [10:0]   q1_reg, q1_next;
    logic [31:0]   tag_sector_reg, tag_sector_next;
    logic [CKW-1:0] tag_chunk_reg, tag_chunk_next;
    logic          line_valid_reg, line_valid_next;
    logic [31:0]   hit_reg, hit_next;
    logic [31:0]   miss_reg, miss_next;
    logic [AW-1:0] pend_start_reg, pend_start_next;
    logic [CW-1:0] pend_count_reg, pend_count_next;
    logic [AW-1:0] fill_pos_reg, fill_pos_next;
    logic          fill_wait_reg, fill_wait_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [CW-1:0] remain_reg, remain_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic          out_last_reg, out_last_next;
    logic [31:0]   out_fsec_reg, out_fsec_next;
    logic [8:0]    out_fofs_reg, out_fofs_next;
    logic [9:0]    out_fcnt_reg, out_fcnt_next;

    // chunk split helpers
    logic [10:0]   x0;
    logic [10:0]   x1;
    logic [22:0]   prod0;
    logic [22:0]   prod1;
    logic [16:0]   r0_wide;
    logic [16:0]   r1_wide;
    logic [10:0]   r0;
    logic [10:0]   r1;
    logic [10:0]   c0;
    logic [10:0]   c1;
    logic [10:0]   r0_fix;
    logic [16:0]   fetch_ofs_wide;
    logic          is_hit;

    always_comb
    begin
        x0    = {2'b00, req_reg.byte_offset};
        x1    = {2'b00, req_reg.byte_offset} + {1'b0, req_reg.byte_count} - 11'd1;
        prod0 = 23'(x0) * 23'(RECIP);
        prod1 = 23'(x1) * 23'(RECIP);

        // estimate is at most one low: one compare and subtract fixes it
        r0_wide = 17'(x0) - 17'(q0_reg) * LB17;
        r1_wide = 17'(x1) - 17'(q1_reg) * LB17;
        r0      = r0_wide[10:0];
        r1      = r1_wide[10:0];
        c0      = (r0 >= LB11) ? (11'(q0_reg) + 11'd1) : 11'(q0_reg);
        c1      = (r1 >= LB11) ? (q1_reg + 11'd1) : q1_reg;
        r0_fix  = (r0 >= LB11) ? (r0 - LB11) : r0;
        fetch_ofs_wide = 17'(c0) * LB17;
        is_hit  = line_valid_reg && (tag_sector_reg == req_reg.sector)
                  && (11'(tag_chunk_reg) == c0);
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        q0_next         = q0_reg;
        q1_next         = q1_reg;
        tag_sector_next = tag_sector_reg;
        tag_chunk_next  = tag_chunk_reg;
        line_valid_next = line_valid_reg;
        hit_next        = hit_reg;
        miss_next       = miss_reg;
        pend_start_next = pend_start_reg;
        pend_count_next = pend_count_reg;
        fill_pos_next   = fill_pos_reg;
        fill_wait_next  = fill_wait_reg;
        rd_addr_next    = rd_addr_reg;
        remain_next     = remain_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_fsec_next   = out_fsec_reg;
        out_fofs_next   = out_fofs_reg;
        out_fcnt_next   = out_fcnt_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (request.opcode)
                        OP_READ:
                        begin
                            if (!fill_wait_reg && (request.byte_count != 10'd0))
                            begin
                                req_next   = request;
                                state_next = ST_DIV;
                            end
                        end
                        OP_FILL:
                        begin
                            if (fill_wait_reg)
                            begin
                                mem_we = 1'b1;
                                if (fill_pos_reg == LAST_POS)
                                begin
                                    fill_wait_next  = 1'b0;
                                    line_valid_next = 1'b1;
                                    fill_pos_next   = '0;
                                    rd_addr_next    = pend_start_reg;
                                    remain_next     = pend_count_reg;
                                    state_next      = ST_EMIT;
                                end
                                else
                                begin
                                    fill_pos_next = fill_pos_reg + AW'(1);
                                end
                            end
                        end
                        OP_FAIL:
                        begin
                            if (fill_wait_reg)
                            begin
                                fill_wait_next  = 1'b0;
                                line_valid_next = 1'b0;
                                fill_pos_next   = '0;
                                out_valid_next  = 1'b1;
                                out_kind_next   = KIND_FAIL;
                                out_last_next   = 1'b0;
                                out_fsec_next   = '0;
                                out_fofs_next   = '0;
                                out_fcnt_next   = '0;
                            end
                        end
                        default:
                        begin
                            // unused opcode: drop
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                q0_next    = prod0[SH+8:SH];
                q1_next    = prod1[SH+10:SH];
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (c0 != c1)
                begin
                    miss_next      = miss_reg + 32'd1;
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_FWD;
                    out_last_next  = 1'b0;
                    out_fsec_next  = req_reg.sector;
                    out_fofs_next  = req_reg.byte_offset;
                    out_fcnt_next  = req_reg.byte_count;
                end
                else if (is_hit)
                begin
                    hit_next     = hit_reg + 32'd1;
                    rd_addr_next = r0_fix[AW-1:0];
                    remain_next  = req_reg.byte_count[CW-1:0];
                    state_next   = ST_EMIT;
                end
                else
                begin
                    miss_next       = miss_reg + 32'd1;
                    tag_sector_next = req_reg.sector;
                    tag_chunk_next  = c0[CKW-1:0];
                    line_valid_next = 1'b0;
                    fill_wait_next  = 1'b1;
                    fill_pos_next   = '0;
                    pend_start_next = r0_fix[AW-1:0];
                    pend_count_next = req_reg.byte_count[CW-1:0];
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_FETCH;
                    out_last_next   = 1'b0;
                    out_fsec_next   = req_reg.sector;
                    out_fofs_next   = fetch_ofs_wide[8:0];
                    out_fcnt_next   = 10'(LINE_BYTES);
                end
            end

            ST_EMIT:
            begin
                mem_re         = 1'b1;
                out_valid_next = 1'b1;
                out_kind_next  = KIND_DATA;
                out_last_next  = (remain_reg == CW'(1));
                out_fsec_next  = '0;
                out_fofs_next  = '0;
                out_fcnt_next  = '0;
                rd_addr_next   = rd_addr_reg + AW'(1);
                remain_next    = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[fill_pos_reg] <= request.fill_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        q0_reg  <= q0_next;
        q1_reg  <= q1_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tag_sector_reg <= '0;
            tag_chunk_reg  <= '0;
            line_valid_reg <= 1'b0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            pend_start_reg <= '0;
            pend_count_reg <= '0;
            fill_pos_reg   <= '0;
            fill_wait_reg  <= 1'b0;
            rd_addr_reg    <= '0;
            remain_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_DATA;
            out_last_reg   <= 1'b0;
            out_fsec_reg   <= '0;
            out_fofs_reg   <= '0;
            out_fcnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tag_sector_reg <= tag_sector_next;
            tag_chunk_reg  <= tag_chunk_next;
            line_valid_reg <= line_valid_next;
            hit_reg        <= hit_next;
            miss_reg       <= miss_next;
            pend_start_reg <= pend_start_next;
            pend_count_reg <= pend_count_next;
            fill_pos_reg   <= fill_pos_next;
            fill_wait_reg  <= fill_wait_next;
            rd_addr_reg    <= rd_addr_next;
            remain_reg     <= remain_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
            out_fsec_reg   <= out_fsec_next;
            out_fofs_reg   <= out_fofs_next;
            out_fcnt_reg   <= out_fcnt_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        result.kind         = out_kind_reg;
        result.data_byte    = (out_kind_reg == KIND_DATA) ? rd_data_reg : 8'd0;
        result.fetch_sector = out_fsec_reg;
        result.fetch_offset = out_fofs_reg;
        result.fetch_count  = out_fcnt_reg;
        result.last_byte    = out_last_reg;
        result.hits_seen    = hit_reg;
        result.misses_seen  = miss_reg;
    end

endmodule

// ===== src/slsrc_checker.sv =====
// Port-level checks for the single-line sector read cache, bound to the top level.
// Depends on slsrc_pkg and the top level's port names.
module slsrc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input slsrc_pkg::req_t request,
    input slsrc_pkg::rsp_t result,
    input logic            result_valid
);
    import slsrc_pkg::*;

    // hit counter moves by at most one per cycle
    a_hits_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result.hits_seen == $past(result.hits_seen))
        || (result.hits_seen == $past(result.hits_seen) + 32'd1))
        else $error("hit counter jumped");

    // forward and fetch beats carry a freshly bumped miss count
    a_miss_bump: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_FWD || result.kind == KIND_FETCH)
        |-> result.misses_seen == $past(result.misses_seen) + 32'd1)
        else $error("miss counter not bumped with forward or fetch beat");

    // a line fetch hands the port back for fill bytes
    a_fetch_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_FETCH) |-> !busy)
        else $error("busy while waiting for fill bytes");

    // a final byte closes the stream
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_DATA) && result.last_byte
        |=> !(result_valid && (result.kind == KIND_DATA)))
        else $error("data beat after final byte");

    // non-data beats carry no byte
    a_nondata_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind != KIND_DATA)
        |-> (result.data_byte == 8'd0) && !result.last_byte)
        else $error("non-data beat carries byte fields");

endmodule

bind single_line_sector_read_cache slsrc_checker u_slsrc_checker (.*);

// ===== bench/line_cache_checker.sv =====
`timescale 1ns / 100ps
// Checker for the single-line sector read cache: predicts result beats and compares them.
// Depends on slsrc_pkg for the request and result structs and the opcode and kind codes.
module line_cache_checker #(
    parameter int unsigned LINE_BYTES = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  slsrc_pkg::req_t request,
    input  slsrc_pkg::rsp_t result,
    input  logic            result_valid,
    output int unsigned     errors,
    output int unsigned     results_due
);
    import slsrc_pkg::*;

    logic [7:0]  line_data [LINE_BYTES];
    logic [31:0] tag_sector;
    int unsigned tag_chunk;
    logic        line_valid;
    logic        fill_open;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    int unsigned want_start;
    int unsigned want_count;
    int unsigned fill_pos;
    rsp_t        due_results [$];

    task automatic queue_result(input kind_t k, input logic [7:0] data,
                                input logic [31:0] sec, input logic [8:0] ofs,
                                input logic [9:0] cnt, input logic last);
        rsp_t r;
        r.kind         = k;
        r.data_byte    = data;
        r.fetch_sector = sec;
        r.fetch_offset = ofs;
        r.fetch_count  = cnt;
        r.last_byte    = last;
        r.hits_seen    = hit_count;
        r.misses_seen  = miss_count;
        due_results.push_back(r);
    endtask

    task automatic queue_line_bytes(input int unsigned first, input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            queue_result(KIND_DATA, line_data[first + i], '0, '0, '0, i + 1 == count);
        end
    endtask

    task automatic predict_results(input req_t rq);
        int unsigned ofs;
        int unsigned cnt;
        int unsigned first_chunk;
        int unsigned last_chunk;
        ofs = rq.byte_offset;
        cnt = rq.byte_count;
        case (rq.opcode)
            OP_READ:
                if (!fill_open && cnt != 0)
                begin
                    first_chunk = ofs / LINE_BYTES;
                    last_chunk  = (ofs + cnt - 1) / LINE_BYTES;
                    if (first_chunk != last_chunk)
                    begin
                        miss_count++;
                        queue_result(KIND_FWD, '0, rq.sector, rq.byte_offset, rq.byte_count,
                                     1'b0);
                    end
                    else if (line_valid && tag_sector == rq.sector && tag_chunk == first_chunk)
                    begin
                        hit_count++;
                        queue_line_bytes(ofs % LINE_BYTES, cnt);
                    end
                    else
                    begin
                        // drop the line until the new fill completes
                        miss_count++;
                        tag_sector = rq.sector;
                        tag_chunk  = first_chunk;
                        line_valid = 1'b0;
                        fill_open  = 1'b1;
                        fill_pos   = 0;
                        want_start = ofs % LINE_BYTES;
                        want_count = cnt;
                        queue_result(KIND_FETCH, '0, rq.sector, 9'(first_chunk * LINE_BYTES),
                                     10'(LINE_BYTES), 1'b0);
                    end
                end
            OP_FILL:
                if (fill_open)
                begin
                    if (fill_pos < LINE_BYTES)
                        line_data[fill_pos] = rq.fill_byte;
                    fill_pos++;
                    if (fill_pos >= LINE_BYTES)
                    begin
                        fill_open  = 1'b0;
                        line_valid = 1'b1;
                        fill_pos   = 0;
                        queue_line_bytes(want_start, want_count);
                    end
                end
            OP_FAIL:
                if (fill_open)
                begin
                    fill_open  = 1'b0;
                    line_valid = 1'b0;
                    fill_pos   = 0;
                    queue_result(KIND_FAIL, '0, '0, '0, '0, 1'b0);
                end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endtask

    task automatic compare_result(input rsp_t got);
        rsp_t want;
        if (due_results.size() == 0)
        begin
            $error("result beat with nothing expected, kind %0d", got.kind);
            errors++;
        end
        else
        begin
            want = due_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("data_byte", want.data_byte, got.data_byte);
            check_field("fetch_sector", want.fetch_sector, got.fetch_sector);
            check_field("fetch_offset", want.fetch_offset, got.fetch_offset);
            check_field("fetch_count", want.fetch_count, got.fetch_count);
            check_field("last_byte", want.last_byte, got.last_byte);
            check_field("hits_seen", want.hits_seen, got.hits_seen);
            check_field("misses_seen", want.misses_seen, got.misses_seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_sector  = '0;
            tag_chunk   = 0;
            line_valid  = 1'b0;
            fill_open   = 1'b0;
            hit_count   = '0;
            miss_count  = '0;
            want_start  = 0;
            want_count  = 0;
            fill_pos    = 0;
            errors      = 0;
            due_results.delete();
            results_due = 0;
        end
        else
        begin
            if (result_valid === 1'b1)
                compare_result(result);
            if (start === 1'b1 && busy === 1'b0)
                predict_results(request);
            results_due = due_results.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Bench top for the single-line sector read cache: clock, reset, request stimulus, verdict.
// Depends on slsrc_pkg, single_line_sector_read_cache and line_cache_checker.
module tb;
    import slsrc_pkg::*;

    localparam int unsigned LINE_BYTES = 32;
    localparam int unsigned CHUNKS     = SECTOR_BYTES / LINE_BYTES;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    rsp_t        result;
    logic        result_valid;
    int unsigned error_count;
    int unsigned results_due;

    // shadow of the line tag, kept only to steer the stimulus
    logic        line_held;
    logic        filling;
    logic [31:0] line_sector;
    int unsigned line_chunk;
    int unsigned fill_count;
    int unsigned live_beats;
    int unsigned idle_pct;
    logic [31:0] sector_pool [4];

    single_line_sector_read_cache #(
        .LINE_BYTES(LINE_BYTES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

    line_cache_checker #(
        .LINE_BYTES(LINE_BYTES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .errors       (error_count),
        .results_due  (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic req_t make_beat(input logic [1:0] op, input logic [31:0] sec,
                                       input logic [8:0] ofs, input logic [9:0] cnt,
                                       input logic [7:0] fb);
        req_t rq;
        rq.opcode      = op;
        rq.sector      = sec;
        rq.byte_offset = ofs;
        rq.byte_count  = cnt;
        rq.fill_byte   = fb;
        return rq;
    endfunction

    // returns 1 when the beat is not simply ignored by the block
    function automatic bit track_beat(input req_t rq);
        int unsigned first_chunk;
        int unsigned last_chunk;
        bit          live;
        live = 1'b0;
        case (rq.opcode)
            OP_READ:
                if (!filling && rq.byte_count != 0)
                begin
                    live        = 1'b1;
                    first_chunk = rq.byte_offset / LINE_BYTES;
                    last_chunk  = (rq.byte_offset + rq.byte_count - 1) / LINE_BYTES;
                    if (first_chunk == last_chunk &&
                        !(line_held && line_sector == rq.sector && line_chunk == first_chunk))
                    begin
                        filling     = 1'b1;
                        line_held   = 1'b0;
                        line_sector = rq.sector;
                        line_chunk  = first_chunk;
                        fill_count  = 0;
                    end
                end
            OP_FILL:
                if (filling)
                begin
                    live = 1'b1;
                    fill_count++;
                    if (fill_count == LINE_BYTES)
                    begin
                        filling   = 1'b0;
                        line_held = 1'b1;
                    end
                end
            OP_FAIL:
                if (filling)
                begin
                    live      = 1'b1;
                    filling   = 1'b0;
                    line_held = 1'b0;
                end
            default:
                ;
        endcase
        return live;
    endfunction

    task automatic send_beat(input req_t rq);
        logic was_busy;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        // busy only moves at the rising edge, so the falling edge shows what the next edge sees
        do
        begin
            @(negedge clk);
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy !== 1'b0);
        if (track_beat(rq))
            live_beats++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        @(posedge clk);
    endtask

    task automatic send_ignored();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        if (pick == 0)
            send_beat(make_beat(OP_UNUSED, $urandom, 9'($urandom), 10'($urandom), 8'($urandom)));
        else if (pick == 1)
            send_beat(make_beat(OP_READ, $urandom, 9'($urandom), '0, 8'($urandom)));
        else if (filling)
            send_beat(make_beat(OP_READ, $urandom, 9'($urandom), 10'($urandom), 8'($urandom)));
        else
            send_beat(make_beat(pick == 2 ? OP_FILL : OP_FAIL, $urandom, 9'($urandom),
                                10'($urandom), 8'($urandom)));
    endtask

    // finish an open fill, with an occasional failure or stray beat in between
    task automatic feed_line();
        int unsigned pick;
        while (filling)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 1)
                send_beat(make_beat(OP_FAIL, $urandom, 9'($urandom), 10'($urandom), 8'($urandom)));
            else if (pick < 5)
                send_ignored();
            else
                send_beat(make_beat(OP_FILL, $urandom, 9'($urandom), 10'($urandom), 8'($urandom)));
        end
    endtask

    task automatic send_line_read();
        logic [31:0] sec;
        int unsigned chunk;
        int unsigned lead;
        int unsigned cnt;
        if ($urandom_range(0, 99) < 65)
            sec = line_sector;
        else if ($urandom_range(0, 99) < 75)
            sec = sector_pool[$urandom_range(0, 3)];
        else
            sec = $urandom;
        chunk = ($urandom_range(0, 99) < 65) ? line_chunk : $urandom_range(0, CHUNKS - 1);
        lead  = $urandom_range(0, LINE_BYTES - 1);
        cnt   = $urandom_range(1, LINE_BYTES - lead);
        send_beat(make_beat(OP_READ, sec, 9'(chunk * LINE_BYTES + lead), 10'(cnt), 8'($urandom)));
        feed_line();
    endtask

    task automatic send_split_read();
        int unsigned ofs;
        int unsigned cnt;
        ofs = $urandom_range(0, SECTOR_BYTES - 1);
        if ($urandom_range(0, 1) == 0)
            cnt = $urandom_range(LINE_BYTES + 1 - ofs % LINE_BYTES, 1023);
        else
            cnt = $urandom_range(LINE_BYTES + 1 - ofs % LINE_BYTES,
                                 2 * LINE_BYTES - ofs % LINE_BYTES);
        send_beat(make_beat(OP_READ, $urandom, 9'(ofs), 10'(cnt), 8'($urandom)));
    endtask

    initial
    begin
        int unsigned random_from;
        int unsigned pick;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        line_held   = 1'b0;
        filling     = 1'b0;
        line_sector = '0;
        line_chunk  = 0;
        fill_count  = 0;
        live_beats  = 0;
        idle_pct    = 34;
        sector_pool[0] = '0;
        sector_pool[1] = '1;
        sector_pool[2] = $urandom;
        sector_pool[3] = $urandom;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // beats that must be ignored while no fill is open
        send_beat(make_beat(OP_FILL, '0, '0, '0, 8'hff));
        send_beat(make_beat(OP_FAIL, '1, '1, '1, '0));
        send_beat(make_beat(OP_UNUSED, '1, '1, '1, '1));
        send_beat(make_beat(OP_READ, 32'h5a5a_a5a5, 9'd7, '0, '0));
        // split across chunks, then running past the end of the sector
        send_beat(make_beat(OP_READ, '0, '0, 10'd512, '0));
        send_beat(make_beat(OP_READ, '1, 9'd511, 10'd1023, '1));
        // miss on the reset tag, a read during the fill, then the fill itself
        send_beat(make_beat(OP_READ, '0, '0, 10'd32, '0));
        send_beat(make_beat(OP_READ, '0, '0, 10'd1, '0));
        for (int unsigned i = 0; i < LINE_BYTES; i++)
            send_beat(make_beat(OP_FILL, '0, '0, '0,
                                i == 0 ? 8'h00 : i == 1 ? 8'hff : 8'($urandom)));
        send_beat(make_beat(OP_READ, '0, '0, 10'd1, '0));
        send_beat(make_beat(OP_READ, '0, 9'd31, 10'd1, '0));
        send_beat(make_beat(OP_READ, '0, '0, 10'd32, '0));
        // top chunk of the top sector: fail part way, then refetch
        send_beat(make_beat(OP_READ, '1, 9'd480, 10'd32, '0));
        for (int unsigned i = 0; i < 5; i++)
            send_beat(make_beat(OP_FILL, '0, '0, '0, 8'($urandom)));
        send_beat(make_beat(OP_FAIL, '0, '0, '0, '0));
        send_beat(make_beat(OP_READ, '1, 9'd480, 10'd1, '0));
        feed_line();
        send_beat(make_beat(OP_READ, '1, 9'd511, 10'd1, '0));

        random_from = live_beats;
        while (live_beats < random_from + 250)
        begin
            if (idle_pct == 34 && live_beats >= random_from + 85)
            begin
                // hold off until every result is out, then switch idle pattern
                drain();
                idle_pct = 64;
            end
            else if (idle_pct == 64 && live_beats >= random_from + 170)
                idle_pct = 0;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_line_read();
            else if (pick < 85)
                send_split_read();
            else
                send_ignored();
        end

        drain();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
